FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define OSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, disabled during reset.
`define OSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/osp_pkg.sv
// ----------------------------------------------------------------------------
// Ordered set package
// Types, sizes and operation codes shared by the ordered set modules.
// ----------------------------------------------------------------------------
package osp_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int KEY_W    = 32;

  localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
  localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_EXISTS = 3'd2;
  localparam logic [2:0] OP_PREV   = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic signed [KEY_W-1:0] key;
  } osp_req_t;

  typedef struct packed {
    logic                    found;
    logic signed [KEY_W-1:0] value;
    logic                    status;
  } osp_res_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } osp_mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PROBE,
    S_NBR,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_EMIT
  } osp_state_t;

endpackage

FILE: rtl/osp_key_ram.sv
// ----------------------------------------------------------------------------
// Key RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module osp_key_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/osp_seq.sv
// ----------------------------------------------------------------------------
// Ordered set sequencer
// Binary search over the sorted key RAM, then neighbour reads or a shift of
// the entries for insert and delete.
// ----------------------------------------------------------------------------
module osp_seq import osp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  input  osp_req_t     req,
  output logic         busy,
  input  logic         slot_free,
  output logic         res_valid,
  output osp_res_t     res,
  output osp_mem_req_t mem_req,
  input  logic [KEY_W-1:0] mem_rdata
);

  osp_state_t       state_r, state_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  osp_res_t         res_r, res_nxt;

  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic             present;
  logic             is_ins;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CNT_W:1];
  assign present = (lo_r < cnt_r) && (mem_rdata == key_r);
  assign is_ins  = (op_r == OP_INSERT);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (req_valid && (req.op <= OP_NEXT)) state_nxt = S_SRCH_RD;
      end
      S_SRCH_RD:  state_nxt = (lo_r < hi_r) ? S_SRCH_CMP : S_PROBE;
      S_SRCH_CMP: state_nxt = S_SRCH_RD;
      S_PROBE: begin
        unique case (op_r)
          OP_INSERT: begin
            if (present)                state_nxt = S_IDLE;
            else if (cnt_r == CAP_CNT)  state_nxt = S_EMIT;
            else if (cnt_r == lo_r)     state_nxt = S_PUT;
            else                        state_nxt = S_SH_RD;
          end
          OP_DELETE: begin
            if (present && (lo_r + 1'b1 < cnt_r)) state_nxt = S_SH_RD;
            else                                  state_nxt = S_IDLE;
          end
          OP_PREV: state_nxt = (lo_r != '0) ? S_NBR : S_EMIT;
          OP_NEXT: begin
            if (present && (lo_r + 1'b1 < cnt_r)) state_nxt = S_NBR;
            else                                  state_nxt = S_EMIT;
          end
          default: state_nxt = S_EMIT;
        endcase
      end
      S_NBR:   state_nxt = S_EMIT;
      S_SH_RD: state_nxt = S_SH_WR;
      S_SH_WR: begin
        if (is_ins) state_nxt = (idx_r - 1'b1 == lo_r) ? S_PUT : S_SH_RD;
        else        state_nxt = (idx_r + 2'd2 == cnt_r) ? S_IDLE : S_SH_RD;
      end
      S_PUT:   state_nxt = S_IDLE;
      S_EMIT:  state_nxt = slot_free ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and RAM requests.
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_r[IDX_W-1:0];
    mem_req.wdata = mem_rdata;
    mem_req.raddr = lo_r[IDX_W-1:0];
    res_valid     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        op_nxt  = req.op;
        key_nxt = req.key ^ SIGN_BIT;
        lo_nxt  = '0;
        hi_nxt  = cnt_r;
        res_nxt = '{found: 1'b0, value: '0, status: 1'b0};
      end
      S_SRCH_RD: begin
        if (lo_r < hi_r) begin
          mem_req.raddr = mid[IDX_W-1:0];
          idx_nxt       = mid;
        end
      end
      S_SRCH_CMP: begin
        if (mem_rdata < key_r) lo_nxt = idx_r + 1'b1;
        else                   hi_nxt = idx_r;
      end
      S_PROBE: begin
        unique case (op_r)
          OP_INSERT: begin
            idx_nxt = cnt_r;
            if (!present && (cnt_r == CAP_CNT)) res_nxt.status = 1'b1;
          end
          OP_DELETE: begin
            idx_nxt = lo_r;
            if (present && !(lo_r + 1'b1 < cnt_r)) cnt_nxt = cnt_r - 1'b1;
          end
          OP_EXISTS: res_nxt.found = present;
          OP_PREV: mem_req.raddr = IDX_W'(lo_r - 1'b1);
          OP_NEXT: begin
            if (present) begin
              mem_req.raddr = IDX_W'(lo_r + 1'b1);
            end else if (lo_r < cnt_r) begin
              res_nxt.found = 1'b1;
              res_nxt.value = mem_rdata ^ SIGN_BIT;
            end
          end
          default: ;
        endcase
      end
      S_NBR: begin
        res_nxt.found = 1'b1;
        res_nxt.value = mem_rdata ^ SIGN_BIT;
      end
      S_SH_RD: begin
        mem_req.raddr = is_ins ? IDX_W'(idx_r - 1'b1) : IDX_W'(idx_r + 1'b1);
      end
      S_SH_WR: begin
        mem_req.we = 1'b1;
        if (is_ins) begin
          idx_nxt = idx_r - 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 2'd2 == cnt_r) cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = lo_r[IDX_W-1:0];
        mem_req.wdata = key_r;
        cnt_nxt       = cnt_r + 1'b1;
      end
      S_EMIT: res_valid = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r  <= op_nxt;
    key_r <= key_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    idx_r <= idx_nxt;
    res_r <= res_nxt;
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule

FILE: rtl/ordered_set_prev_next.sv
// ----------------------------------------------------------------------------
// Ordered set with predecessor and successor
// Sorted key store in one RAM with insert, delete, exists, prev and next.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload    Handshake
// in_       input      osp_req_t  in_valid / in_stall
// out_      output     osp_res_t  out_valid / out_stall
//
// A request runs a binary search over the n stored keys, each probe being
// one RAM read, then forms the answer; the block goes back to idle before
// the next request is taken. Insert and delete then shift the entries above
// the key, each one read and then written through the single RAM port pair.
// Reset empties the set at once.
// A result waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module ordered_set_prev_next import osp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  osp_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output osp_res_t out_data
);

  osp_mem_req_t     mem_req;
  logic [KEY_W-1:0] mem_rdata;
  logic             busy;
  logic             slot_free;
  logic             res_valid;
  osp_res_t         res;
  logic             out_valid_r;
  osp_res_t         out_data_r;

  osp_key_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W)) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  osp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (in_data),
    .busy      (busy),
    .slot_free (slot_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res_valid;
    end
    if (slot_free && res_valid) begin
      out_data_r <= res;
    end
  end

  assign in_stall  = busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/osp_checker.sv
// ----------------------------------------------------------------------------
// Ordered set checker
// Port-level checks of the ordered set, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module osp_checker import osp_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input osp_req_t in_data,
  input logic     out_valid,
  input logic     out_stall,
  input osp_res_t out_data
);

  `OSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `OSP_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (in_data.op <= OP_NEXT), in_stall)
  `OSP_ASSERT_SAME(a_drop_nf, out_valid && out_data.status, !out_data.found)
  `OSP_ASSERT_SAME(a_nf_zero, out_valid && !out_data.found, out_data.value == '0)

endmodule

bind ordered_set_prev_next osp_checker u_osp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
